[hw/rtl/bslpc_pkg.sv]
// types and constants shared by the button press classifier
package bslpc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLDOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_UP_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_KEYCODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_KEYCODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MODIFIER    = 3'd5;

    localparam logic [15:0] RELEASE_HOLDOFF_RST = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST      = 16'd750;
    localparam logic [15:0] KEY_UP_DELAY_RST    = 16'd30;
    localparam logic [7:0]  LONG_KEYCODE_RST    = 8'd43;
    localparam logic [7:0]  SHORT_KEYCODE_RST   = 8'd10;
    localparam logic [7:0]  KEY_MODIFIER_RST    = 8'd8;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        raw_pressed;
        logic        host_ready;
    } in_t;

    typedef struct packed {
        logic       send_key_up;
        logic       send_key;
        logic [7:0] report_modifier;
        logic [7:0] report_keycode;
        logic [1:0] press_kind;
    } out_t;

    typedef struct packed {
        logic [15:0] release_holdoff_ms;
        logic [15:0] long_press_ms;
        logic [15:0] key_up_delay_ms;
        logic [7:0]  long_keycode;
        logic [7:0]  short_keycode;
        logic [7:0]  key_modifier;
    } cfg_t;

    typedef struct packed {
        logic        debounced_down;
        logic [31:0] last_raw_high_ms;
        logic        held_before;
        logic [31:0] press_start_ms;
        logic        long_done;
        logic        key_up_pending;
        logic [31:0] key_up_due_ms;
    } state_t;

endpackage

[hw/rtl/bslpc_core.sv]
// per-poll debounce and short/long press decision with next-state logic
module bslpc_core (
    input  bslpc_pkg::cfg_t   cfg,
    input  bslpc_pkg::state_t st,
    input  bslpc_pkg::in_t    beat,
    output bslpc_pkg::state_t st_next,
    output bslpc_pkg::out_t   res
);
    import bslpc_pkg::*;

    logic [31:0] since_high;
    logic [31:0] since_due;
    logic [31:0] since_press;
    logic [31:0] due_at;

    assign since_high  = beat.now_ms - st.last_raw_high_ms;
    assign since_due   = beat.now_ms - st.key_up_due_ms;
    assign since_press = beat.now_ms - st.press_start_ms;
    assign due_at      = beat.now_ms + {16'd0, cfg.key_up_delay_ms};

    always_comb
    begin
        st_next = st;
        res     = '0;

        // debounce: press at once, release after hold-off
        if (beat.raw_pressed)
        begin
            st_next.debounced_down   = 1'b1;
            st_next.last_raw_high_ms = beat.now_ms;
        end
        else if (since_high > {16'd0, cfg.release_holdoff_ms})
        begin
            st_next.debounced_down = 1'b0;
        end

        // wrap-safe key-up due check on pre-poll pending state
        if (st.key_up_pending && !since_due[31] && beat.host_ready)
        begin
            res.send_key_up        = 1'b1;
            st_next.key_up_pending = 1'b0;
        end

        if (st_next.debounced_down && !st.held_before)
        begin
            st_next.press_start_ms = beat.now_ms;
            st_next.held_before    = 1'b1;
            st_next.long_done      = 1'b0;
        end
        else if (st_next.debounced_down && st.held_before)
        begin
            if (!st.long_done && since_press >= {16'd0, cfg.long_press_ms}
                && beat.host_ready)
            begin
                res.send_key           = 1'b1;
                res.report_modifier    = cfg.key_modifier;
                res.report_keycode     = cfg.long_keycode;
                res.press_kind         = KIND_LONG;
                st_next.long_done      = 1'b1;
                st_next.key_up_pending = 1'b1;
                st_next.key_up_due_ms  = due_at;
            end
        end
        else if (!st_next.debounced_down && st.held_before)
        begin
            if (!st.long_done && beat.host_ready)
            begin
                res.send_key           = 1'b1;
                res.report_modifier    = cfg.key_modifier;
                res.report_keycode     = cfg.short_keycode;
                res.press_kind         = KIND_SHORT;
                st_next.key_up_pending = 1'b1;
                st_next.key_up_due_ms  = due_at;
            end
            st_next.held_before = 1'b0;
        end
    end

endmodule

[hw/rtl/button_short_long_press_classifier.sv]
// Single-button short/long press classifier. Each input beat is one poll
// (timestamp in ms, raw button bit, host-ready flag) and yields exactly one
// result beat. A poll passes through an input register and the decision is
// made combinationally into the result register, so one poll is taken every
// clock while the result side keeps up; an unread result stalls the poll.
// The user must write configuration registers through the plain write port
// only while no poll is in flight; the block itself does not enforce this.
module button_short_long_press_classifier (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  bslpc_pkg::in_t                         in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output bslpc_pkg::out_t                        out_data,
    input  logic                                   cfg_we,
    input  logic [bslpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bslpc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bslpc_pkg::*;

    cfg_t   cfg_reg;
    state_t st_reg;
    state_t st_next;
    in_t    beat_reg;
    logic   beat_valid_reg;
    out_t   res_next;
    out_t   res_reg;
    logic   res_valid_reg;
    logic   advance;
    logic   in_fire;

    assign advance   = beat_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !beat_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    bslpc_core u_core (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .beat    (beat_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_holdoff_ms <= RELEASE_HOLDOFF_RST;
            cfg_reg.long_press_ms      <= LONG_PRESS_RST;
            cfg_reg.key_up_delay_ms    <= KEY_UP_DELAY_RST;
            cfg_reg.long_keycode       <= LONG_KEYCODE_RST;
            cfg_reg.short_keycode      <= SHORT_KEYCODE_RST;
            cfg_reg.key_modifier       <= KEY_MODIFIER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RELEASE_HOLDOFF: cfg_reg.release_holdoff_ms <= cfg_data;
                REG_LONG_PRESS:      cfg_reg.long_press_ms      <= cfg_data;
                REG_KEY_UP_DELAY:    cfg_reg.key_up_delay_ms    <= cfg_data;
                REG_LONG_KEYCODE:    cfg_reg.long_keycode       <= cfg_data[7:0];
                REG_SHORT_KEYCODE:   cfg_reg.short_keycode      <= cfg_data[7:0];
                REG_KEY_MODIFIER:    cfg_reg.key_modifier       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control and classifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            st_reg         <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                beat_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            beat_reg <= in_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    a_no_key_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.send_key |->
            res_reg.press_kind == KIND_NONE && res_reg.report_keycode == 8'd0
            && res_reg.report_modifier == 8'd0)
        else $error("key fields set without a key report");

    a_key_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.send_key |->
            res_reg.press_kind == KIND_LONG || res_reg.press_kind == KIND_SHORT)
        else $error("key report without a press kind");

    a_key_arms_up: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.send_key |=> st_reg.key_up_pending)
        else $error("key report did not arm key-up");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !beat_valid_reg || advance)
        else $error("input register overwritten");

    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        advance && st_reg.long_done && st_reg.held_before |->
            res_next.press_kind == KIND_NONE)
        else $error("second key report for one press");

endmodule
